### design/fpa_pkg.sv
// shared constants, default size table and control structs of the fit allocator
package fpa_pkg;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_LOAD    = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_FIT       = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX    = 2'd2;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic finish;
  } fpa_cmd_t;

  typedef struct packed {
    logic cmp_last;
    logic out_free;
  } fpa_sts_t;

  // power-on size of each block; blocks past the tenth start at zero
  function automatic logic [31:0] default_size(input logic [5:0] idx);
    logic [31:0] sz;
    case (idx)
      6'd0:    sz = 32'd100;
      6'd1:    sz = 32'd250;
      6'd2:    sz = 32'd80;
      6'd3:    sz = 32'd300;
      6'd4:    sz = 32'd150;
      6'd5:    sz = 32'd500;
      6'd6:    sz = 32'd120;
      6'd7:    sz = 32'd200;
      6'd8:    sz = 32'd350;
      6'd9:    sz = 32'd90;
      default: sz = 32'd0;
    endcase
    return sz;
  endfunction

endpackage

### design/fpa_intf.sv
// request and result channel interfaces of the fit allocator

interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] req_size;
  logic [5:0]  block_index;
  logic [15:0] load_size;

  modport source (output valid, func, req_size, block_index, load_size, input ready);
  modport sink   (input valid, func, req_size, block_index, load_size, output ready);
endinterface

interface fpa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] slot_index;

  modport source (output valid, status, slot_index, input ready);
  modport sink   (input valid, status, slot_index, output ready);
endinterface

### design/fixed_partition_fit_allocator.sv
// allocate: the result word follows a scan of every block through the one read port of the size ram
// release and load: no scan; the result word is registered once the output register is free
// one item is worked on at a time: a new item is taken only after the previous one has finished
// a new item is taken while the previous result word still waits on the output
// reset: fit policy first fit, all blocks free, sizes read as power-on defaults until loaded
// reset needs no clearing pass; the block accepts items in the first cycle after reset
module fixed_partition_fit_allocator #(
  parameter int NUM_BLOCKS = 10,
  parameter int SIZE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  fpa_in_if.sink      in_ch,
  fpa_out_if.source   out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_fit_policy
);
  import fpa_pkg::*;

  logic [1:0] fit_policy_r;
  fpa_cmd_t   cmd;
  fpa_sts_t   sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POL_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      fit_policy_r <= cfg_fit_policy;
    end
  end

  fpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ch.ready)
  );

  fpa_dp #(.NUM_BLOCKS(NUM_BLOCKS), .SIZE_WIDTH(SIZE_WIDTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_ch.func),
    .in_req_size    (in_ch.req_size),
    .in_block_index (in_ch.block_index),
    .in_load_size   (in_ch.load_size),
    .fit_policy     (fit_policy_r),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_slot_index (out_ch.slot_index)
  );

  // one item in flight: no second word taken right after one is accepted
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, out_ch.slot_index} < 7'(NUM_BLOCKS)))
    else $error("result slot beyond the block table");

  a_err_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_OK)) |-> (out_ch.slot_index == 6'd0))
    else $error("error result carries a nonzero slot");

endmodule

### design/fpa_ram.sv
// generic single write port ram with registered read
module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fpa_ctrl.sv
// sequencing state machine of the fit allocator
module fpa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  input  fpa_pkg::fpa_sts_t sts,
  output fpa_pkg::fpa_cmd_t cmd,
  output logic             in_ready
);
  import fpa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd.capture    = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.finish     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          if (in_func == FUNC_ALLOC) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (sts.cmp_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register can take the word
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/fpa_dp.sv
// size table, busy marks, fit scan and result register of the fit allocator
module fpa_dp #(
  parameter int NUM_BLOCKS = 10,
  parameter int SIZE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fpa_pkg::fpa_cmd_t cmd,
  output fpa_pkg::fpa_sts_t sts,
  input  logic [1:0]        in_func,
  input  logic [15:0]       in_req_size,
  input  logic [5:0]        in_block_index,
  input  logic [15:0]       in_load_size,
  input  logic [1:0]        fit_policy,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [5:0]        out_slot_index
);
  import fpa_pkg::*;

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = (SIZE_WIDTH > 16) ? SIZE_WIDTH : 16;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

  // captured item
  logic [1:0]  func_r;
  logic [15:0] req_r;
  logic [5:0]  idx_r;
  logic [15:0] load_r;

  logic [NUM_BLOCKS-1:0] busy_r;
  logic [NUM_BLOCKS-1:0] vld_r;

  logic [IW-1:0]         rd_idx_r;
  logic                  rd_act_r;
  logic [IW-1:0]         cmp_idx_r;
  logic                  cmp_act_r;
  logic                  vld_q_r;
  logic                  found_r;
  logic [IW-1:0]         best_idx_r;
  logic [SIZE_WIDTH-1:0] best_size_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [5:0]            out_slot_r;

  logic [SIZE_WIDTH-1:0] ram_q;
  logic [SIZE_WIDTH-1:0] size_c;
  logic                  fits;
  logic                  take;
  logic                  idx_ok;
  logic [IW-1:0]         idx_sel;
  logic                  busy_at;
  logic                  wr_en;
  logic [1:0]            res_status;
  logic [5:0]            res_slot;

  assign idx_ok  = ({1'b0, idx_r} < 7'(NUM_BLOCKS));
  assign idx_sel = idx_r[IW-1:0];
  assign busy_at = idx_ok && busy_r[idx_sel];
  assign wr_en   = cmd.finish && (func_r == FUNC_LOAD) && idx_ok;

  fpa_ram #(.WIDTH(SIZE_WIDTH), .DEPTH(NUM_BLOCKS)) u_size_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_sel),
    .wdata (SIZE_WIDTH'(load_r)),
    .raddr (rd_idx_r),
    .rdata (ram_q)
  );

  // entries never loaded read as their power-on size
  assign size_c = vld_q_r ? ram_q : SIZE_WIDTH'(default_size(6'(cmp_idx_r)));
  assign fits   = !busy_r[cmp_idx_r] && (CW'(size_c) >= CW'(req_r));

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (fit_policy == POL_BEST) begin
        take = (size_c < best_size_r);
      end else if (fit_policy == POL_WORST) begin
        take = (size_c > best_size_r);
      end
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_slot   = 6'd0;
    case (func_r)
      FUNC_ALLOC: begin
        if (found_r) begin
          res_slot = 6'(best_idx_r);
        end else begin
          res_status = ST_NO_FIT;
        end
      end
      FUNC_RELEASE: begin
        if (!idx_ok) begin
          res_status = ST_BAD_INDEX;
        end else if (!busy_at) begin
          res_status = ST_ALREADY_FREE;
        end else begin
          res_slot = idx_r;
        end
      end
      FUNC_LOAD: begin
        if (!idx_ok) begin
          res_status = ST_BAD_INDEX;
        end else begin
          res_slot = idx_r;
        end
      end
      default: begin
        res_status = ST_OK;
        res_slot   = 6'd0;
      end
    endcase
  end

  assign sts.cmp_last = cmp_act_r && (cmp_idx_r == LAST_IDX);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      req_r  <= in_req_size;
      idx_r  <= in_block_index;
      load_r <= in_load_size;
    end
    cmp_idx_r <= rd_idx_r;
    vld_q_r   <= vld_r[rd_idx_r];
    if (cmp_act_r && take) begin
      best_idx_r  <= cmp_idx_r;
      best_size_r <= size_c;
    end
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      vld_r       <= '0;
      rd_idx_r    <= '0;
      rd_act_r    <= 1'b0;
      cmp_act_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_act_r <= rd_act_r;
      if (cmd.scan_start) begin
        rd_idx_r <= '0;
        rd_act_r <= 1'b1;
        found_r  <= 1'b0;
      end else begin
        if (rd_act_r) begin
          rd_idx_r <= rd_idx_r + 1'b1;
          if (rd_idx_r == LAST_IDX) begin
            rd_act_r <= 1'b0;
          end
        end
        if (cmp_act_r && take) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if ((func_r == FUNC_ALLOC) && found_r) begin
          busy_r[best_idx_r] <= 1'b1;
        end
        if ((func_r == FUNC_RELEASE) && busy_at) begin
          busy_r[idx_sel] <= 1'b0;
        end
        if (wr_en) begin
          vld_r[idx_sel] <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
